[rtl/sapphire_pkg.sv]
// ----------------------------------------------------------------------------
// sapphire_pkg
// Shared types, command codes and helpers for the Sapphire II cipher core.
// ----------------------------------------------------------------------------
package sapphire_pkg;

    localparam logic [1:0] CMD_DATA    = 2'd0;
    localparam logic [1:0] CMD_KEY     = 2'd1;
    localparam logic [1:0] CMD_DEFAULT = 2'd2;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [3:0] CRYPT_LAST = 4'd15;
    localparam logic [3:0] SWAP_LAST  = 4'd3;
    localparam logic [3:0] FINAL_LAST = 4'd5;
    localparam logic [3:0] TRIES_MAX  = 4'd11;

    localparam logic [7:0] ROTOR_INIT   = 8'd1;
    localparam logic [7:0] RATCHET_INIT = 8'd3;
    localparam logic [7:0] AVAL_INIT    = 8'd5;
    localparam logic [7:0] PLAIN_INIT   = 8'd7;
    localparam logic [7:0] CIPHER_INIT  = 8'd11;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] in_byte;
        logic       key_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       kind;
    } t_out_beat;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_KEY,
        OP_KEY_LAST,
        OP_DEFAULT,
        OP_DATA_LATCH,
        OP_FILL,
        OP_DRAW_RD,
        OP_DRAW_ACC,
        OP_SWAP,
        OP_FINAL,
        OP_CRYPT,
        OP_RESULT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] step;
        logic       kind;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
        logic draw_ok;
        logic k_is_one;
    } t_stat;

    // all ones at and below the top set bit
    function automatic logic [7:0] smear(input logic [7:0] v);
        logic [7:0] m;
        m = v | (v >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        return m;
    endfunction

endpackage

[rtl/sapphire_ctrl.sv]
// ----------------------------------------------------------------------------
// sapphire_ctrl
// Sequencer: input/output handshake, deck fill, key schedule and crypt steps.
// ----------------------------------------------------------------------------
module sapphire_ctrl import sapphire_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_beat i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_stat    i_stat,
    output t_cmd     o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_FILL     = 8'b0000_0010,
        S_CRYPT    = 8'b0000_0100,
        S_DRAW_RD  = 8'b0000_1000,
        S_DRAW_ACC = 8'b0001_0000,
        S_SWAP     = 8'b0010_0000,
        S_FINAL    = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_step, n_step;
    logic       r_sched, n_sched;
    logic       r_notify, n_notify;
    logic       r_kind, n_kind;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid & o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_sched     = r_sched;
        n_notify    = r_notify;
        n_kind      = r_kind;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd.op    = OP_IDLE;
        o_cmd.step  = r_step;
        o_cmd.kind  = r_kind;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_data.cmd)
                        CMD_DATA: begin
                            o_cmd.op = OP_DATA_LATCH;
                            n_kind   = KIND_DATA;
                            n_step   = 4'd0;
                            n_state  = S_CRYPT;
                        end
                        CMD_KEY: begin
                            if (i_in_data.key_last) begin
                                o_cmd.op = OP_KEY_LAST;
                                n_sched  = 1'b1;
                                n_kind   = KIND_DONE;
                                n_state  = S_FILL;
                            end else begin
                                o_cmd.op = OP_KEY;
                            end
                        end
                        CMD_DEFAULT: begin
                            o_cmd.op = OP_DEFAULT;
                            n_sched  = 1'b0;
                            n_notify = 1'b1;
                            n_kind   = KIND_DONE;
                            n_state  = S_FILL;
                        end
                        default: ;
                    endcase
                end
            end
            S_FILL: begin
                o_cmd.op = OP_FILL;
                if (i_stat.fill_last) begin
                    if (r_sched) begin
                        n_state = S_DRAW_RD;
                    end else if (r_notify) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DRAW_RD: begin
                o_cmd.op = OP_DRAW_RD;
                n_state  = S_DRAW_ACC;
            end
            S_DRAW_ACC: begin
                o_cmd.op = OP_DRAW_ACC;
                n_step   = 4'd0;
                n_state  = i_stat.draw_ok ? S_SWAP : S_DRAW_RD;
            end
            S_SWAP: begin
                o_cmd.op = OP_SWAP;
                n_step   = r_step + 4'd1;
                if (r_step == SWAP_LAST) begin
                    n_step  = 4'd0;
                    n_state = i_stat.k_is_one ? S_FINAL : S_DRAW_RD;
                end
            end
            S_FINAL: begin
                o_cmd.op = OP_FINAL;
                n_step   = r_step + 4'd1;
                if (r_step == FINAL_LAST) begin
                    n_sched = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_CRYPT: begin
                o_cmd.op = OP_CRYPT;
                n_step   = r_step + 4'd1;
                if (r_step == CRYPT_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_RESULT;
                    n_out_valid = 1'b1;
                    n_notify    = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_step      <= 4'd0;
            r_sched     <= 1'b0;
            r_notify    <= 1'b0;
            r_kind      <= KIND_DONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_sched     <= n_sched;
            r_notify    <= n_notify;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/sapphire_dp.sv]
// ----------------------------------------------------------------------------
// sapphire_dp
// Deck and key memories, cipher indices, draw logic and result register.
// ----------------------------------------------------------------------------
module sapphire_dp import sapphire_pkg::*; #(
    parameter int KEY_BYTES_MAX = 255
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_beat  i_in_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    output t_stat     o_stat,
    output t_out_beat o_out_data
);

    localparam logic [7:0] KeyMax = 8'(KEY_BYTES_MAX);

    logic [7:0] r_deck [256];
    logic [7:0] r_key [256];
    logic [7:0] r_rd, r_krd;

    logic [7:0] r_rotor, r_ratchet, r_aval, r_plain, r_cipher;
    logic [7:0] r_fcnt, r_kcnt, r_klen;
    logic       r_fdesc, r_decrypt;
    logic [7:0] r_k, r_sum, r_pos, r_j, r_t, r_held, r_acc, r_m1, r_in_byte, r_res;
    logic [3:0] r_tries;
    t_out_beat  r_out;

    logic       we, key_we;
    logic [7:0] raddr, waddr, wdata;

    logic [7:0] mask, s_base, s_new, val0, val, mix, res;
    logic [8:0] pos_inc;
    logic       wrap;
    logic [3:0] tries_n;

    assign key_we = ((i_cmd.op == OP_KEY) || (i_cmd.op == OP_KEY_LAST)) && (r_kcnt < KeyMax);

    assign mask    = smear(r_k);
    assign s_base  = r_rd + r_krd;
    assign pos_inc = {1'b0, r_pos} + 9'd1;
    assign wrap    = pos_inc >= {1'b0, r_klen};
    assign s_new   = wrap ? s_base + r_klen : s_base;
    assign tries_n = r_tries + 4'd1;
    assign val0    = mask & s_new;
    assign val     = ((tries_n > TRIES_MAX) && (val0 >= r_k)) ? val0 - r_k : val0;
    assign mix     = r_m1 ^ r_rd;
    assign res     = r_in_byte ^ mix;

    assign o_stat.fill_last = (r_fcnt == 8'hFF);
    assign o_stat.draw_ok   = (val <= r_k);
    assign o_stat.k_is_one  = (r_k == 8'd1);
    assign o_out_data       = r_out;

    always_comb begin
        we    = 1'b0;
        raddr = r_sum;
        waddr = r_fcnt;
        wdata = r_fdesc ? ~r_fcnt : r_fcnt;
        case (i_cmd.op)
            OP_FILL: we = 1'b1;
            OP_SWAP: begin
                case (i_cmd.step)
                    4'd0: raddr = r_k;
                    4'd1: raddr = r_j;
                    4'd2: begin
                        we = 1'b1; waddr = r_k; wdata = r_rd;
                    end
                    default: begin
                        we = 1'b1; waddr = r_j; wdata = r_t;
                    end
                endcase
            end
            OP_FINAL: begin
                case (i_cmd.step)
                    4'd0: raddr = ROTOR_INIT;
                    4'd1: raddr = RATCHET_INIT;
                    4'd2: raddr = AVAL_INIT;
                    4'd3: raddr = PLAIN_INIT;
                    default: raddr = r_sum;
                endcase
            end
            OP_CRYPT: begin
                case (i_cmd.step)
                    4'd0: raddr = r_rotor;
                    4'd1: raddr = r_cipher;
                    4'd2: raddr = r_ratchet;
                    4'd3: begin
                        we = 1'b1; waddr = r_cipher; wdata = r_rd; raddr = r_plain;
                    end
                    4'd4: begin
                        we = 1'b1; waddr = r_ratchet; wdata = r_rd; raddr = r_rotor;
                    end
                    4'd5: begin
                        we = 1'b1; waddr = r_plain; wdata = r_rd;
                    end
                    4'd6: begin
                        we = 1'b1; waddr = r_rotor; wdata = r_held; raddr = r_held;
                    end
                    4'd7:  raddr = r_ratchet;
                    4'd8:  raddr = r_rotor;
                    4'd9:  raddr = r_acc + r_rd;
                    4'd10: raddr = r_plain;
                    4'd11: raddr = r_cipher;
                    4'd12: raddr = r_aval;
                    4'd13: raddr = r_acc + r_rd;
                    4'd14: raddr = r_rd;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_deck[waddr] <= wdata;
        end
        if (we && (waddr == raddr)) begin
            r_rd <= wdata;
        end else begin
            r_rd <= r_deck[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key[r_kcnt] <= i_in_data.in_byte;
        end
        r_krd <= r_key[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotor   <= ROTOR_INIT;
            r_ratchet <= RATCHET_INIT;
            r_aval    <= AVAL_INIT;
            r_plain   <= PLAIN_INIT;
            r_cipher  <= CIPHER_INIT;
            r_fcnt    <= 8'd0;
            r_fdesc   <= 1'b1;
            r_kcnt    <= 8'd0;
            r_decrypt <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_decrypt <= i_cfg_data;
            end
            case (i_cmd.op)
                OP_KEY: begin
                    if (key_we) begin
                        r_kcnt <= r_kcnt + 8'd1;
                    end
                end
                OP_KEY_LAST: begin
                    r_klen  <= key_we ? r_kcnt + 8'd1 : r_kcnt;
                    r_kcnt  <= 8'd0;
                    r_fcnt  <= 8'd0;
                    r_fdesc <= 1'b0;
                    r_k     <= 8'hFF;
                    r_sum   <= 8'd0;
                    r_pos   <= 8'd0;
                    r_tries <= 4'd0;
                end
                OP_DEFAULT: begin
                    r_rotor   <= ROTOR_INIT;
                    r_ratchet <= RATCHET_INIT;
                    r_aval    <= AVAL_INIT;
                    r_plain   <= PLAIN_INIT;
                    r_cipher  <= CIPHER_INIT;
                    r_kcnt    <= 8'd0;
                    r_fcnt    <= 8'd0;
                    r_fdesc   <= 1'b1;
                end
                OP_DATA_LATCH: r_in_byte <= i_in_data.in_byte;
                OP_FILL: r_fcnt <= r_fcnt + 8'd1;
                OP_DRAW_ACC: begin
                    r_sum   <= s_new;
                    r_pos   <= wrap ? 8'd0 : pos_inc[7:0];
                    r_tries <= tries_n;
                    r_j     <= val;
                end
                OP_SWAP: begin
                    if (i_cmd.step == 4'd1) begin
                        r_t <= r_rd;
                    end
                    if (i_cmd.step == SWAP_LAST) begin
                        r_k     <= r_k - 8'd1;
                        r_tries <= 4'd0;
                    end
                end
                OP_FINAL: begin
                    case (i_cmd.step)
                        4'd1: r_rotor   <= r_rd;
                        4'd2: r_ratchet <= r_rd;
                        4'd3: r_aval    <= r_rd;
                        4'd4: r_plain   <= r_rd;
                        4'd5: r_cipher  <= r_rd;
                        default: ;
                    endcase
                end
                OP_CRYPT: begin
                    case (i_cmd.step)
                        4'd1: begin
                            r_ratchet <= r_ratchet + r_rd;
                            r_rotor   <= r_rotor + 8'd1;
                        end
                        4'd2:  r_held <= r_rd;
                        4'd7:  r_aval <= r_aval + r_rd;
                        4'd8:  r_acc  <= r_rd;
                        4'd10: r_m1   <= r_rd;
                        4'd11: r_acc  <= r_rd;
                        4'd12: r_acc  <= r_acc + r_rd;
                        4'd15: begin
                            r_res <= res;
                            if (r_decrypt) begin
                                r_plain  <= res;
                                r_cipher <= r_in_byte;
                            end else begin
                                r_cipher <= res;
                                r_plain  <= r_in_byte;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_RESULT: begin
                    r_out.kind     <= i_cmd.kind;
                    r_out.out_byte <= i_cmd.kind ? 8'd0 : r_res;
                end
                default: ;
            endcase
        end
    end

endmodule

[rtl/sapphire_stream_cipher_core.sv]
// Data beat: 16 deck-port steps, then the result; no new beat is taken until it is issued.
// Key beat not last: byte stored (up to KEY_BYTES_MAX), input stays ready. Default init:
// deck fill, then result. Last key beat: deck fill, then per deck slot 255..1 draw tries
// (read, then accumulate; up to 12 tries) and a swap, then the cipher index reads; bound by
// the one deck port. Reset (synchronous, active low) starts a deck fill; no beat is taken
// until it ends. Configuration writes are taken at any time outside reset.
// ----------------------------------------------------------------------------
// sapphire_stream_cipher_core
// Byte-wide Sapphire II stream cipher with key schedule and default init.
// ----------------------------------------------------------------------------
module sapphire_stream_cipher_core import sapphire_pkg::*; #(
    parameter int KEY_BYTES_MAX = 255
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    sapphire_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sapphire_dp #(
        .KEY_BYTES_MAX (KEY_BYTES_MAX)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_valid & o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule

[rtl/sapphire_checker.sv]
// ----------------------------------------------------------------------------
// sapphire_checker
// Port-level checks on the cipher core, bound to the top level.
// ----------------------------------------------------------------------------
module sapphire_checker import sapphire_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_beat  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    a_data_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.cmd == CMD_DATA) |=> !o_in_ready)
        else $error("ready after data beat before its result");

    a_key_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.cmd == CMD_KEY) && !i_in_data.key_last
        |=> o_in_ready)
        else $error("non-final key beat stalled input");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind |-> (o_out_data.out_byte == 8'd0))
        else $error("init-done beat with nonzero byte");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("activity right after reset");

endmodule

bind sapphire_stream_cipher_core sapphire_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
